### rtl/core/twac_pkg.sv
// Shared types and constants for the three-axis window average capture block.
package twac_pkg;

    localparam int AXES     = 3;
    localparam int ACT_W    = 3;
    localparam int ORIENT_W = 3;
    localparam int WS_W     = 9;
    localparam logic [WS_W-1:0] WS_RESET = 9'd100;

    localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GRAB   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    localparam int QDEPTH = 2;
    localparam int QPW    = 1;
    localparam int QCW    = 2;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_START,
        OP_STOP,
        OP_GRAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ORIENT_W-1:0] orient;
        logic                orient_ok;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPDATE,
        BK_DSTART,
        BK_DWAIT
    } bk_state_t;

endpackage

### rtl/core/twac_if.sv
// Channel interfaces: command input, result output and window size write.
interface twac_in_if #(parameter int SAMPLE_BITS = 16);
    logic                                 valid;
    logic                                 ready;
    logic [twac_pkg::ACT_W-1:0]           action;
    logic signed [SAMPLE_BITS-1:0]        sample_x;
    logic signed [SAMPLE_BITS-1:0]        sample_y;
    logic signed [SAMPLE_BITS-1:0]        sample_z;
    logic [twac_pkg::ORIENT_W-1:0]        orientation;

    modport source (output valid, action, sample_x, sample_y, sample_z, orientation,
                    input ready);
    modport sink   (input valid, action, sample_x, sample_y, sample_z, orientation,
                    output ready);
endinterface

interface twac_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic                          new_average;
    logic signed [SAMPLE_BITS-1:0] mean_x;
    logic signed [SAMPLE_BITS-1:0] mean_y;
    logic signed [SAMPLE_BITS-1:0] mean_z;
    logic                          grab_accepted;
    logic                          set_complete;
    logic signed [SAMPLE_BITS-1:0] column_x;
    logic signed [SAMPLE_BITS-1:0] column_y;
    logic signed [SAMPLE_BITS-1:0] column_z;

    modport source (output valid, new_average, mean_x, mean_y, mean_z, grab_accepted,
                    set_complete, column_x, column_y, column_z, input ready);
    modport sink   (input valid, new_average, mean_x, mean_y, mean_z, grab_accepted,
                    set_complete, column_x, column_y, column_z, output ready);
endinterface

interface twac_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [twac_pkg::WS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/twac_front.sv
// Front end: command acceptance, action decode and two-entry command queue.
module twac_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int NUM_COLUMNS = 6
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    twac_in_if.sink                                cmd,
    input  logic                                   pop,
    output twac_pkg::head_t                        head,
    output logic [twac_pkg::AXES*SAMPLE_BITS-1:0]  head_smp
);

    localparam int VW = twac_pkg::AXES * SAMPLE_BITS;

    twac_pkg::cmd_t                  dec;
    twac_pkg::cmd_t                  q_cmd_reg [twac_pkg::QDEPTH];
    logic [VW-1:0]                   q_smp_reg [twac_pkg::QDEPTH];
    logic [twac_pkg::QPW-1:0]        wr_ptr_reg;
    logic [twac_pkg::QPW-1:0]        rd_ptr_reg;
    logic [twac_pkg::QCW-1:0]        cnt_reg;
    logic                            push;

    always_comb
    begin
        dec.orient    = cmd.orientation;
        dec.orient_ok = int'(cmd.orientation) < NUM_COLUMNS;
        case (cmd.action)
            twac_pkg::ACT_SAMPLE: dec.op = twac_pkg::OP_SAMPLE;
            twac_pkg::ACT_START:  dec.op = twac_pkg::OP_START;
            twac_pkg::ACT_STOP:   dec.op = twac_pkg::OP_STOP;
            twac_pkg::ACT_GRAB:   dec.op = twac_pkg::OP_GRAB;
            twac_pkg::ACT_CLEAR:  dec.op = twac_pkg::OP_CLEAR;
            twac_pkg::ACT_READ:   dec.op = twac_pkg::OP_READ;
            default:              dec.op = twac_pkg::OP_NOP;
        endcase
    end

    assign cmd.ready = (cnt_reg != twac_pkg::QCW'(twac_pkg::QDEPTH));
    assign push      = cmd.valid && cmd.ready;

    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_cmd_reg[rd_ptr_reg];
    assign head_smp   = q_smp_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + twac_pkg::QPW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + twac_pkg::QPW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + twac_pkg::QCW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - twac_pkg::QCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg] <= dec;
            q_smp_reg[wr_ptr_reg] <= {cmd.sample_x, cmd.sample_y, cmd.sample_z};
        end
    end

endmodule

### rtl/core/twac_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module twac_div #(
    parameter int SUM_W       = 25,
    parameter int WCNT_W      = 9,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic [WCNT_W-1:0]             divisor,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [SUM_W-1:0]   work_reg;
    logic [WCNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]   div_u;
    logic [SUM_W-1:0]   abs_in;
    logic [WCNT_W:0]    trial;
    logic               ge;
    logic [WCNT_W-1:0]  rem_step;

    assign div_u    = dividend;
    assign abs_in   = div_u[SUM_W-1] ? (~div_u + SUM_W'(1)) : div_u;
    assign trial    = {rem_reg, work_reg[SUM_W-1]};
    assign ge       = trial >= {1'b0, divisor};
    assign rem_step = ge ? WCNT_W'(trial - {1'b0, divisor}) : trial[WCNT_W-1:0];

    assign done     = done_reg;
    assign quotient = neg_reg ? SAMPLE_BITS'(~work_reg + SUM_W'(1))
                              : SAMPLE_BITS'(work_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= div_u[SUM_W-1];
            work_reg <= abs_in;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step;
            work_reg <= {work_reg[SUM_W-2:0], ge};
        end
    end

endmodule

### rtl/core/twac_back.sv
// Back end: sample ring, running sums, mean division, columns and result register.
module twac_back #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int NUM_COLUMNS = 6
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  twac_pkg::head_t                        head,
    input  logic [twac_pkg::AXES*SAMPLE_BITS-1:0]  head_smp,
    output logic                                   pop,
    twac_out_if.source                             result,
    twac_cfg_if.sink                               cfg
);

    localparam int AXES   = twac_pkg::AXES;
    localparam int VW     = AXES * SAMPLE_BITS;
    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int WCNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + AW + 1;
    localparam int EW     = (WCNT_W > twac_pkg::WS_W) ? WCNT_W : twac_pkg::WS_W;
    localparam int COL_IW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    twac_pkg::bk_state_t           state_reg;
    twac_pkg::bk_state_t           state_next;

    logic [twac_pkg::WS_W-1:0]     ws_reg;
    logic [EW-1:0]                 ws_ext;
    logic [WCNT_W-1:0]             w_eff;
    logic [WCNT_W-1:0]             fill_reg;
    logic [WCNT_W-1:0]             fill_upd;
    logic [AW-1:0]                 wp_reg;
    logic [AW-1:0]                 wp_upd;
    logic                          full_now;
    logic                          full_upd;
    logic signed [SUM_W-1:0]       sum_reg [AXES];
    logic signed [SUM_W-1:0]       sum_upd [AXES];
    logic signed [SAMPLE_BITS-1:0] old_s [AXES];
    logic signed [SAMPLE_BITS-1:0] new_s [AXES];
    logic signed [SAMPLE_BITS-1:0] mean_reg [AXES];
    logic signed [SAMPLE_BITS-1:0] div_q [AXES];
    logic [AXES-1:0]               div_done;
    logic                          div_all;
    logic                          collecting_reg;

    logic [VW-1:0]                 ring_mem [MAX_WINDOW];
    logic [VW-1:0]                 rd_data_reg;
    logic [VW-1:0]                 smp_reg;

    logic [VW-1:0]                 col_reg [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0]        col_set;
    logic [COL_IW-1:0]             oidx;
    logic                          grab_ok;

    logic                          out_valid_reg;
    logic                          new_avg_reg;
    logic                          grab_reg;
    logic [VW-1:0]                 colout_reg;
    logic                          out_free;

    logic                          take_smp;
    logic                          mem_we;
    logic                          div_start;
    logic                          fin_idle;
    logic                          fin_upd;
    logic                          fin_div;
    logic                          fin_any;

    assign cfg.ready = 1'b1;

    assign ws_ext = EW'(ws_reg);
    always_comb
    begin
        if (ws_ext == '0)
        begin
            w_eff = WCNT_W'(1);
        end
        else if (ws_ext > EW'(MAX_WINDOW))
        begin
            w_eff = WCNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WCNT_W'(ws_ext);
        end
    end

    assign full_now = fill_reg >= w_eff;
    assign fill_upd = full_now ? fill_reg : fill_reg + WCNT_W'(1);
    assign full_upd = fill_upd >= w_eff;
    assign wp_upd   = ((WCNT_W'(wp_reg) + WCNT_W'(1)) == w_eff) ? '0 : wp_reg + AW'(1);

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            old_s[a]   = rd_data_reg[(AXES-1-a)*SAMPLE_BITS +: SAMPLE_BITS];
            new_s[a]   = smp_reg[(AXES-1-a)*SAMPLE_BITS +: SAMPLE_BITS];
            sum_upd[a] = sum_reg[a] - (full_now ? SUM_W'(old_s[a]) : SUM_W'(0))
                         + SUM_W'(new_s[a]);
        end
    end

    assign oidx    = COL_IW'(head.cmd.orient);
    assign grab_ok = collecting_reg && full_now && head.cmd.orient_ok;

    always_comb
    begin
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            col_set[c] = |col_reg[c];
        end
    end

    assign div_all  = &div_done;
    assign out_free = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twac_pkg::BK_IDLE:
            begin
                if (head.valid && out_free && head.cmd.op == twac_pkg::OP_SAMPLE
                    && collecting_reg)
                begin
                    state_next = twac_pkg::BK_UPDATE;
                end
            end
            twac_pkg::BK_UPDATE:
            begin
                state_next = full_upd ? twac_pkg::BK_DSTART : twac_pkg::BK_IDLE;
            end
            twac_pkg::BK_DSTART:
            begin
                state_next = twac_pkg::BK_DWAIT;
            end
            twac_pkg::BK_DWAIT:
            begin
                if (div_all)
                begin
                    state_next = twac_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = twac_pkg::BK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        take_smp  = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        fin_idle  = 1'b0;
        fin_upd   = 1'b0;
        fin_div   = 1'b0;
        case (state_reg)
            twac_pkg::BK_IDLE:
            begin
                pop      = head.valid && out_free;
                take_smp = pop && head.cmd.op == twac_pkg::OP_SAMPLE && collecting_reg;
                fin_idle = pop && !take_smp;
            end
            twac_pkg::BK_UPDATE:
            begin
                mem_we  = 1'b1;
                fin_upd = !full_upd;
            end
            twac_pkg::BK_DSTART:
            begin
                div_start = 1'b1;
            end
            twac_pkg::BK_DWAIT:
            begin
                fin_div = div_all;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign fin_any = fin_idle || fin_upd || fin_div;

    for (genvar a = 0; a < AXES; a++)
    begin : g_div
        twac_div #(
            .SUM_W       (SUM_W),
            .WCNT_W      (WCNT_W),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_twac_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (sum_reg[a]),
            .divisor  (w_eff),
            .done     (div_done[a]),
            .quotient (div_q[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= twac_pkg::BK_IDLE;
            ws_reg         <= twac_pkg::WS_RESET;
            fill_reg       <= '0;
            wp_reg         <= '0;
            collecting_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a]  <= '0;
                mean_reg[a] <= '0;
            end
            for (int c = 0; c < NUM_COLUMNS; c++)
            begin
                col_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // window size write empties the window
            if (cfg.valid)
            begin
                ws_reg   <= cfg.data;
                fill_reg <= '0;
                wp_reg   <= '0;
                for (int a = 0; a < AXES; a++)
                begin
                    sum_reg[a] <= '0;
                end
            end

            if (fin_idle)
            begin
                case (head.cmd.op)
                    twac_pkg::OP_START:
                    begin
                        if (!collecting_reg)
                        begin
                            collecting_reg <= 1'b1;
                            fill_reg       <= '0;
                            wp_reg         <= '0;
                            for (int a = 0; a < AXES; a++)
                            begin
                                sum_reg[a] <= '0;
                            end
                        end
                    end
                    twac_pkg::OP_STOP:
                    begin
                        collecting_reg <= 1'b0;
                    end
                    twac_pkg::OP_GRAB:
                    begin
                        if (grab_ok)
                        begin
                            col_reg[oidx] <= {mean_reg[0], mean_reg[1], mean_reg[2]};
                        end
                    end
                    twac_pkg::OP_CLEAR:
                    begin
                        for (int c = 0; c < NUM_COLUMNS; c++)
                        begin
                            col_reg[c] <= '0;
                        end
                    end
                    default:
                    begin
                        collecting_reg <= collecting_reg;
                    end
                endcase
            end

            if (mem_we)
            begin
                fill_reg <= fill_upd;
                wp_reg   <= wp_upd;
                for (int a = 0; a < AXES; a++)
                begin
                    sum_reg[a] <= sum_upd[a];
                end
            end

            if (fin_div)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    mean_reg[a] <= div_q[a];
                end
            end

            if (fin_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_smp)
        begin
            rd_data_reg <= ring_mem[wp_reg];
            smp_reg     <= head_smp;
        end
        if (mem_we)
        begin
            ring_mem[wp_reg] <= smp_reg;
        end
        if (fin_any)
        begin
            new_avg_reg <= fin_div;
            grab_reg    <= fin_idle && head.cmd.op == twac_pkg::OP_GRAB && grab_ok;
            if (fin_idle && head.cmd.op == twac_pkg::OP_READ && head.cmd.orient_ok)
            begin
                colout_reg <= col_reg[oidx];
            end
            else
            begin
                colout_reg <= '0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.new_average   = new_avg_reg;
    assign result.mean_x        = mean_reg[0];
    assign result.mean_y        = mean_reg[1];
    assign result.mean_z        = mean_reg[2];
    assign result.grab_accepted = grab_reg;
    assign result.set_complete  = &col_set;
    assign result.column_x      = colout_reg[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign result.column_y      = colout_reg[SAMPLE_BITS +: SAMPLE_BITS];
    assign result.column_z      = colout_reg[0 +: SAMPLE_BITS];

endmodule

### rtl/core/triaxial_window_average_capture.sv
// Top level of the three-axis sliding window average with orientation capture.
//
//  channel  | kind       | transfer when       | carries
//  ---------+------------+---------------------+--------------------------------------
//  cmd      | in, v/r    | cmd.valid & ready   | action, sample_x/y/z, orientation
//  result   | out, v/r   | result.valid & rdy  | new_average, mean_x/y/z, grab_accepted,
//           |            |                     | set_complete, column_x/y/z
//  cfg      | in, v/r    | cfg.valid & ready   | window_size (always ready)
//
//  A full-window sample runs BK_IDLE, BK_UPDATE, BK_DSTART and BK_DWAIT; BK_DWAIT lasts until
//  the bit-serial dividers, one per axis, run side by side, are all done.
//  A sample that leaves the window short ends in BK_UPDATE; every other action ends in BK_IDLE.
//  A two-entry command queue takes transfers while the back end works or a result waits.
//  rst_n clears control state at once; the sample ring needs no clearing pass.
//  A stalled result holds; the back end starts the next command only as it drains.
module triaxial_window_average_capture #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int NUM_COLUMNS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    twac_in_if.sink     cmd,
    twac_out_if.source  result,
    twac_cfg_if.sink    cfg
);

    twac_pkg::head_t                        head;
    logic [twac_pkg::AXES*SAMPLE_BITS-1:0]  head_smp;
    logic                                   pop;

    twac_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_twac_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .pop      (pop),
        .head     (head),
        .head_smp (head_smp)
    );

    twac_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_twac_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_smp (head_smp),
        .pop      (pop),
        .result   (result),
        .cfg      (cfg)
    );

endmodule

### rtl/core/twac_checker.sv
// Port-level checks for the window average block and their binding.
module twac_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic                   new_average,
    input logic                   grab_accepted,
    input logic [SAMPLE_BITS-1:0] column_x,
    input logic [SAMPLE_BITS-1:0] column_y,
    input logic [SAMPLE_BITS-1:0] column_z
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result offered straight out of reset");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(new_average && grab_accepted))
        else $error("mean and grab flagged in one result");

    a_mean_no_column: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (new_average || grab_accepted) |->
            column_x == '0 && column_y == '0 && column_z == '0)
        else $error("column data outside a read");

endmodule

bind triaxial_window_average_capture twac_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_twac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .new_average   (result.new_average),
    .grab_accepted (result.grab_accepted),
    .column_x      (result.column_x),
    .column_y      (result.column_y),
    .column_z      (result.column_z)
);
